[design/pmv_pkg.sv]
// ----------------------------------------------------------------------------
// pmv_pkg
// shared types and constants of the panoptic majority vote merge unit
// ----------------------------------------------------------------------------
package pmv_pkg;

    localparam int CNT_W   = 22;
    localparam int RANK_W  = 7;
    localparam int LABEL_W = 24;
    localparam int CLS_W   = 8;
    localparam int INST_W  = 6;
    localparam int CFG_W   = 64;
    localparam int DIV_W   = 17;

    localparam logic [CNT_W-1:0]   CNT_MAX   = 22'h3FFFFF;
    localparam logic [RANK_W-1:0]  RANK_MAX  = 7'd127;
    localparam logic [LABEL_W-1:0] LABEL_MAX = 24'hFFFFFF;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_COLLECT = 2'd1;
    localparam logic [1:0] CMD_FINISH  = 2'd2;
    localparam logic [1:0] CMD_LABEL   = 2'd3;

    localparam logic [2:0] REG_MASK0   = 3'd0;
    localparam logic [2:0] REG_MASK1   = 3'd1;
    localparam logic [2:0] REG_MASK2   = 3'd2;
    localparam logic [2:0] REG_MASK3   = 3'd3;
    localparam logic [2:0] REG_DIVISOR = 3'd4;
    localparam logic [2:0] REG_LIMIT   = 3'd5;
    localparam logic [2:0] REG_VOID    = 3'd6;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic tclr_step;
        logic scan_init;
        logic scan_issue;
        logic vote_wr;
        logic inst_step;
        logic set_voted;
        logic coll_wr;
        logic lbl_mul;
        logic lbl_out;
    } pmv_ctrl_t;

    typedef struct packed {
        logic clr_last;
        logic tally_last;
        logic scan_last;
        logic inst_last;
        logic out_blocked;
    } pmv_stat_t;

endpackage

[design/pmv_ram.sv]
// ----------------------------------------------------------------------------
// pmv_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module pmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/pmv_ctrl.sv]
// ----------------------------------------------------------------------------
// pmv_ctrl
// command sequencer: clear sweeps, collect, vote walk and label steps
// ----------------------------------------------------------------------------
module pmv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        cmd,
    output logic              in_stall,
    input  pmv_pkg::pmv_stat_t stat,
    output pmv_pkg::pmv_ctrl_t ctrl
);
    import pmv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_COLL_RD, S_COLL_WR, S_TCLR, S_SCAN, S_DRAIN,
        S_TRD, S_VWR, S_LRD, S_LMUL, S_LOUT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    case (cmd)
                        CMD_START:   state_next = S_CLR;
                        CMD_COLLECT: state_next = S_COLL_RD;
                        CMD_FINISH:  state_next = S_TCLR;
                        default:     state_next = S_LRD;
                    endcase
                end
            end
            S_CLR:
            begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_COLL_RD: state_next = S_COLL_WR;
            S_COLL_WR:
            begin
                ctrl.coll_wr = 1'b1;
                state_next   = S_IDLE;
            end
            S_TCLR:
            begin
                ctrl.tclr_step = 1'b1;
                if (stat.tally_last)
                begin
                    ctrl.scan_init = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_TRD;
            S_TRD:   state_next = S_VWR;
            S_VWR:
            begin
                ctrl.vote_wr = 1'b1;
                if (stat.inst_last)
                begin
                    ctrl.set_voted = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctrl.inst_step = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_LRD: state_next = S_LMUL;
            S_LMUL:
            begin
                ctrl.lbl_mul = 1'b1;
                state_next   = S_LOUT;
            end
            S_LOUT:
            begin
                if (!stat.out_blocked)
                begin
                    ctrl.lbl_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[design/pmv_datapath.sv]
// ----------------------------------------------------------------------------
// pmv_datapath
// configuration, stores, counters, vote compare and label arithmetic
// ----------------------------------------------------------------------------
module pmv_datapath #(
    parameter int NUM_CLASSES   = 256,
    parameter int NUM_INSTANCES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [pmv_pkg::CFG_W-1:0]     cfg_data,
    input  logic [1:0]                    cmd,
    input  logic [pmv_pkg::CLS_W-1:0]     semantic_class,
    input  logic [pmv_pkg::INST_W-1:0]    instance_id,
    input  pmv_pkg::pmv_ctrl_t            ctrl,
    output pmv_pkg::pmv_stat_t            stat,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pmv_pkg::LABEL_W-1:0]   panoptic_label
);
    import pmv_pkg::*;

    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IW = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
    localparam int HW = IW + CW;
    localparam int HD = NUM_INSTANCES * (2 ** CW);

    // configuration
    logic [4*CFG_W-1:0] mask_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic [CLS_W-1:0]   void_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            div_reg   <= DIV_W'(256);
            limit_reg <= '0;
            void_reg  <= CLS_W'(255);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASK0:   mask_reg[0*CFG_W +: CFG_W] <= cfg_data;
                REG_MASK1:   mask_reg[1*CFG_W +: CFG_W] <= cfg_data;
                REG_MASK2:   mask_reg[2*CFG_W +: CFG_W] <= cfg_data;
                REG_MASK3:   mask_reg[3*CFG_W +: CFG_W] <= cfg_data;
                REG_DIVISOR: div_reg   <= cfg_data[DIV_W-1:0];
                REG_LIMIT:   limit_reg <= cfg_data[CNT_W-1:0];
                REG_VOID:    void_reg  <= cfg_data[CLS_W-1:0];
                default:     ;
            endcase
        end
    end

    // item and control registers
    logic [1:0]        cmd_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [INST_W-1:0] inst_reg;
    logic [HW-1:0]     cnt_reg;
    logic [IW-1:0]     ic_reg;
    logic              voted_reg;
    logic              cmp_vld_reg;
    logic [CW-1:0]     cmp_cls_reg;
    logic [CNT_W-1:0]  best_reg;
    logic [CW-1:0]     best_cls_reg;
    logic [24:0]       prod_reg;
    logic [RANK_W-1:0] num_reg;
    logic              zero_reg;
    logic              out_valid_reg;
    logic [LABEL_W-1:0] label_reg;

    logic [15:0]       cls_w, inst_w;
    logic [CW-1:0]     cls_idx;
    logic [IW-1:0]     inst_idx;
    logic              cls_ok, inst_ok, thing;

    assign cls_w    = 16'(cls_reg);
    assign inst_w   = 16'(inst_reg);
    assign cls_idx  = cls_w[CW-1:0];
    assign inst_idx = inst_w[IW-1:0];
    assign cls_ok   = cls_w < 16'(NUM_CLASSES);
    assign inst_ok  = inst_w < 16'(NUM_INSTANCES);
    assign thing    = mask_reg[cls_reg];

    // stores
    logic            hist_we, area_we, tally_we;
    logic [HW-1:0]   hist_waddr, hist_raddr;
    logic [CNT_W-1:0] hist_wdata, hist_rdata, area_wdata, area_rdata;
    logic [CW-1:0]   area_waddr, tally_waddr;
    logic [RANK_W-1:0] tally_wdata, tally_rdata, rank_wdata, rank_rdata;
    logic [CLS_W-1:0] fc_rdata;
    logic            present;
    logic [RANK_W-1:0] tally_inc;

    assign present   = (best_reg != '0);
    assign tally_inc = (tally_rdata < RANK_MAX) ? tally_rdata + 1'b1 : tally_rdata;

    always_comb
    begin
        hist_we     = 1'b0;
        hist_waddr  = {inst_idx, cls_idx};
        hist_wdata  = (hist_rdata < CNT_MAX) ? hist_rdata + 1'b1 : hist_rdata;
        area_we     = 1'b0;
        area_waddr  = cls_idx;
        area_wdata  = (area_rdata < CNT_MAX) ? area_rdata + 1'b1 : area_rdata;
        tally_we    = 1'b0;
        tally_waddr = best_cls_reg;
        tally_wdata = tally_inc;
        rank_wdata  = present ? tally_inc : '0;
        hist_raddr  = ctrl.scan_issue ? {ic_reg, cnt_reg[CW-1:0]} : {inst_idx, cls_idx};
        if (ctrl.clr_step)
        begin
            hist_we    = 1'b1;
            hist_waddr = cnt_reg;
            hist_wdata = '0;
            area_we    = ({1'b0, cnt_reg} < (HW+1)'(NUM_CLASSES));
            area_waddr = cnt_reg[CW-1:0];
            area_wdata = '0;
        end
        else if (ctrl.coll_wr && cls_ok)
        begin
            area_we = !thing;
            hist_we = thing && inst_ok;
        end
        if (ctrl.tclr_step)
        begin
            tally_we    = 1'b1;
            tally_waddr = cnt_reg[CW-1:0];
            tally_wdata = '0;
        end
        else if (ctrl.vote_wr)
        begin
            tally_we = present;
        end
    end

    pmv_ram #(.WIDTH(CNT_W), .DEPTH(HD), .AW(HW)) u_hist (
        .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
        .raddr(hist_raddr), .rdata(hist_rdata)
    );

    pmv_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CLASSES), .AW(CW)) u_area (
        .clk(clk), .we(area_we), .waddr(area_waddr), .wdata(area_wdata),
        .raddr(cls_idx), .rdata(area_rdata)
    );

    pmv_ram #(.WIDTH(RANK_W), .DEPTH(NUM_CLASSES), .AW(CW)) u_tally (
        .clk(clk), .we(tally_we), .waddr(tally_waddr), .wdata(tally_wdata),
        .raddr(best_cls_reg), .rdata(tally_rdata)
    );

    pmv_ram #(.WIDTH(CLS_W), .DEPTH(NUM_INSTANCES), .AW(IW)) u_final (
        .clk(clk), .we(ctrl.vote_wr && present), .waddr(ic_reg),
        .wdata(CLS_W'(best_cls_reg)), .raddr(inst_idx), .rdata(fc_rdata)
    );

    pmv_ram #(.WIDTH(RANK_W), .DEPTH(NUM_INSTANCES), .AW(IW)) u_rank (
        .clk(clk), .we(ctrl.vote_wr), .waddr(ic_reg), .wdata(rank_wdata),
        .raddr(inst_idx), .rdata(rank_rdata)
    );

    // label arithmetic
    logic [CNT_W-1:0]  area_eff;
    logic [CLS_W-1:0]  oc;
    logic              lbl_zero;
    logic [25:0]       sum;

    assign area_eff = cls_ok ? area_rdata : '0;
    assign lbl_zero = thing && !(inst_ok && voted_reg && rank_rdata != '0);
    assign sum      = 26'(prod_reg) + 26'(num_reg);

    always_comb
    begin
        if (thing)
        begin
            oc = fc_rdata;
        end
        else if (limit_reg != '0 && area_eff <= limit_reg)
        begin
            oc = void_reg;
        end
        else
        begin
            oc = cls_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ic_reg        <= '0;
            voted_reg     <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= ctrl.scan_issue;
            if (ctrl.load || ctrl.scan_init || ctrl.inst_step)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.clr_step || ctrl.tclr_step || ctrl.scan_issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctrl.load)
            begin
                ic_reg <= '0;
            end
            else if (ctrl.inst_step)
            begin
                ic_reg <= ic_reg + 1'b1;
            end
            if (ctrl.set_voted)
            begin
                voted_reg <= 1'b1;
            end
            if (ctrl.lbl_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd;
            cls_reg  <= semantic_class;
            inst_reg <= instance_id;
        end
        if (ctrl.scan_issue)
        begin
            cmp_cls_reg <= cnt_reg[CW-1:0];
        end
        if (ctrl.scan_init || ctrl.inst_step)
        begin
            best_reg     <= '0;
            best_cls_reg <= '0;
        end
        else if (cmp_vld_reg && hist_rdata > best_reg)
        begin
            best_reg     <= hist_rdata;
            best_cls_reg <= cmp_cls_reg;
        end
        if (ctrl.lbl_mul)
        begin
            prod_reg <= oc * div_reg;
            num_reg  <= thing ? rank_rdata : '0;
            zero_reg <= lbl_zero;
        end
        if (ctrl.lbl_out)
        begin
            if (zero_reg || cmd_reg != CMD_LABEL)
            begin
                label_reg <= '0;
            end
            else if (sum > 26'(LABEL_MAX))
            begin
                label_reg <= LABEL_MAX;
            end
            else
            begin
                label_reg <= sum[LABEL_W-1:0];
            end
        end
    end

    assign stat.clr_last    = (cnt_reg == HW'(HD - 1));
    assign stat.tally_last  = (cnt_reg[CW-1:0] == CW'(NUM_CLASSES - 1));
    assign stat.scan_last   = (cnt_reg[CW-1:0] == CW'(NUM_CLASSES - 1));
    assign stat.inst_last   = (ic_reg == IW'(NUM_INSTANCES - 1));
    assign stat.out_blocked = out_valid_reg && out_stall;

    assign out_valid      = out_valid_reg;
    assign panoptic_label = label_reg;

endmodule

[design/panoptic_majority_vote_merge_unit.sv]
// ----------------------------------------------------------------------------
// panoptic_majority_vote_merge_unit
// majority vote merge of semantic class and instance id into panoptic labels
// ----------------------------------------------------------------------------
// the input channel (in_valid, in_stall) takes one item per command: start
// frame, collect pixel, finish vote or label pixel. only label items give a
// result item on the output channel (out_valid, out_stall).
// one item is worked at a time; in_stall is high while it is in progress.
// collect reads the histogram and area rams, then writes them.
// label steps through ram read, multiply by the divisor and saturation into the
// output register.
// start frame sweeps the histogram ram one entry a cycle, clearing all
// NUM_INSTANCES * 2**clog2(NUM_CLASSES) entries and the area ram with it.
// finish clears all NUM_CLASSES tally ram entries, then for each instance walks
// the histogram one entry a cycle and ends in drain, tally read and vote write.
// after reset the same histogram clearing sweep runs before the first item is
// taken; configuration writes are taken during it.
// a stalled output holds its item; the next item is still taken, but a label
// item waits in its last step until the output register is free.
// ----------------------------------------------------------------------------
module panoptic_majority_vote_merge_unit #(
    parameter int NUM_CLASSES   = 256,
    parameter int NUM_INSTANCES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [pmv_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   cmd,
    input  logic [pmv_pkg::CLS_W-1:0]    semantic_class,
    input  logic [pmv_pkg::INST_W-1:0]   instance_id,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pmv_pkg::LABEL_W-1:0]  panoptic_label
);
    import pmv_pkg::*;

    pmv_ctrl_t ctrl;
    pmv_stat_t stat;

    pmv_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .cmd(cmd),
        .in_stall(in_stall), .stat(stat), .ctrl(ctrl)
    );

    pmv_datapath #(.NUM_CLASSES(NUM_CLASSES), .NUM_INSTANCES(NUM_INSTANCES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .semantic_class(semantic_class),
        .instance_id(instance_id), .ctrl(ctrl), .stat(stat),
        .out_valid(out_valid), .out_stall(out_stall),
        .panoptic_label(panoptic_label)
    );

endmodule

[design/pmv_checker.sv]
// ----------------------------------------------------------------------------
// pmv_checker
// port level checks of the merge unit
// ----------------------------------------------------------------------------
module pmv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] panoptic_label
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(panoptic_label))
        else $error("stalled output item changed");

    // every accepted item keeps the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // a result only appears after the block was working
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output item without work");

    // a new result never appears while the input is idle
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && !$past(in_stall) && !$past(out_valid) |-> !out_valid)
        else $error("output item from idle block");

endmodule

bind panoptic_majority_vote_merge_unit pmv_checker u_pmv_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .panoptic_label(panoptic_label)
);

[tb/panoptic_majority_vote_merge_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// panoptic_majority_vote_merge_unit_test
// self-checking bench for the panoptic majority vote merge unit
// ----------------------------------------------------------------------------
// frames are streamed as start, a collect pass, finish and a label pass, with
// stray labels mixed into the collect pass. a local model of the vote and the
// labelling predicts every label item; the output side checks them in order.
// thing masks, divisor, area limit and void class change between frames.
// both channels idle and stall in random bursts, except in the last frames.
// ----------------------------------------------------------------------------
module panoptic_majority_vote_merge_unit_test;
    import pmv_pkg::*;

    localparam int N_CLS      = 256;
    localparam int N_INST     = 64;
    localparam int IDLE_LIMIT = 200000;
    localparam int N_FRAMES   = 14;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = REG_MASK0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          cmd = CMD_START;
    logic [CLS_W-1:0]    semantic_class = '0;
    logic [INST_W-1:0]   instance_id = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [LABEL_W-1:0]  panoptic_label;

    panoptic_majority_vote_merge_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .semantic_class(semantic_class), .instance_id(instance_id),
        .out_valid(out_valid), .out_stall(out_stall), .panoptic_label(panoptic_label)
    );

    always #4 clk = ~clk;

    // model state
    logic [63:0]        thing_mask [4];
    logic [DIV_W-1:0]   divisor;
    logic [CNT_W-1:0]   area_limit;
    logic [CLS_W-1:0]   void_class;
    logic [CNT_W-1:0]   vote_hist [N_INST][N_CLS];
    logic [CNT_W-1:0]   stuff_area [N_CLS];
    logic [CLS_W-1:0]   inst_class [N_INST];
    logic [RANK_W-1:0]  inst_rank [N_INST];
    logic [RANK_W-1:0]  class_tally [N_CLS];

    logic [LABEL_W-1:0] pending_labels [$];
    int errors = 0;
    int items_sent = 0;
    int labels_checked = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    int stall_left = 0;

    function automatic bit thing_class(input logic [CLS_W-1:0] c);
        return thing_mask[c[7:6]][c[5:0]];
    endfunction

    function automatic logic [LABEL_W-1:0] pack_label(input logic [CLS_W-1:0] c,
                                                      input logic [RANK_W-1:0] n);
        logic [63:0] v;
        v = 64'(c) * 64'(divisor) + 64'(n);
        return (v > 64'(LABEL_MAX)) ? LABEL_MAX : v[LABEL_W-1:0];
    endfunction

    task automatic run_vote();
        logic [CNT_W-1:0] best;
        logic [CLS_W-1:0] best_cls;
        bit present;
        for (int c = 0; c < N_CLS; c++) class_tally[c] = '0;
        for (int i = 0; i < N_INST; i++)
        begin
            best = '0;
            best_cls = '0;
            present = 1'b0;
            for (int c = 0; c < N_CLS; c++)
            begin
                if (vote_hist[i][c] > best)
                begin
                    best = vote_hist[i][c];
                    best_cls = CLS_W'(c);
                    present = 1'b1;
                end
            end
            if (!present)
                inst_rank[i] = '0;
            else
            begin
                if (class_tally[best_cls] < RANK_MAX)
                    class_tally[best_cls] = class_tally[best_cls] + 1'b1;
                inst_class[i] = best_cls;
                inst_rank[i] = class_tally[best_cls];
            end
        end
    endtask

    task automatic apply_item(input logic [1:0] op, input logic [CLS_W-1:0] c,
                              input logic [INST_W-1:0] n);
        logic [CLS_W-1:0] oc;
        case (op)
            CMD_START:
            begin
                for (int i = 0; i < N_INST; i++)
                    for (int k = 0; k < N_CLS; k++) vote_hist[i][k] = '0;
                for (int k = 0; k < N_CLS; k++) stuff_area[k] = '0;
            end
            CMD_COLLECT:
            begin
                if (!thing_class(c))
                begin
                    if (stuff_area[c] < CNT_MAX) stuff_area[c] = stuff_area[c] + 1'b1;
                end
                else if (vote_hist[n][c] < CNT_MAX)
                    vote_hist[n][c] = vote_hist[n][c] + 1'b1;
            end
            CMD_FINISH: run_vote();
            default:
            begin
                if (thing_class(c))
                    pending_labels.push_back(inst_rank[n] != '0 ?
                        pack_label(inst_class[n], inst_rank[n]) : '0);
                else
                begin
                    oc = (area_limit != '0 && stuff_area[c] <= area_limit) ? void_class : c;
                    pending_labels.push_back(pack_label(oc, '0));
                end
            end
        endcase
    endtask

    // sends one item and updates the model when it is taken
    task automatic send_item(input logic [1:0] op, input logic [CLS_W-1:0] c,
                             input logic [INST_W-1:0] n);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        semantic_class <= c;
        instance_id <= n;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        apply_item(op, c, n);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_labels.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_config(input logic [63:0] m0, input logic [63:0] m1,
                              input logic [63:0] m2, input logic [63:0] m3,
                              input logic [DIV_W-1:0] dv, input logic [CNT_W-1:0] lim,
                              input logic [CLS_W-1:0] vc);
        logic [CFG_W-1:0] vals [7];
        logic [2:0] idx [7];
        vals = '{m0, m1, m2, m3, 64'(dv), 64'(lim), 64'(vc)};
        idx = '{REG_MASK0, REG_MASK1, REG_MASK2, REG_MASK3, REG_DIVISOR, REG_LIMIT, REG_VOID};
        for (int k = 0; k < 7; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= vals[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        thing_mask = '{m0, m1, m2, m3};
        divisor = dv;
        area_limit = lim;
        void_class = vc;
    endtask

    // output side: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // result check, sampled mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pending_labels.size() == 0)
            begin
                $display("%0t: unexpected label item, expected none, actual %h",
                         $time, panoptic_label);
                errors++;
            end
            else
            begin
                if (panoptic_label !== pending_labels[0])
                begin
                    $display("%0t: panoptic_label mismatch, expected %h, actual %h",
                             $time, pending_labels[0], panoptic_label);
                    errors++;
                end
                void'(pending_labels.pop_front());
                labels_checked++;
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic test_directed();
        set_config(64'h61, 64'h0, 64'h0, 64'h8000_0000_0000_0000, 17'd256, 22'd2, 8'd255);
        send_item(CMD_LABEL, 8'd0, 6'd5);
        send_item(CMD_START, 8'd0, 6'd0);
        send_item(CMD_COLLECT, 8'd5, 6'd63);
        send_item(CMD_COLLECT, 8'd6, 6'd63);
        send_item(CMD_COLLECT, 8'd6, 6'd63);
        send_item(CMD_COLLECT, 8'd5, 6'd63);
        send_item(CMD_COLLECT, 8'd255, 6'd0);
        send_item(CMD_COLLECT, 8'd5, 6'd10);
        send_item(CMD_COLLECT, 8'd7, 6'd1);
        send_item(CMD_COLLECT, 8'd7, 6'd2);
        send_item(CMD_COLLECT, 8'd7, 6'd3);
        send_item(CMD_COLLECT, 8'd8, 6'd63);
        send_item(CMD_FINISH, 8'd0, 6'd0);
        send_item(CMD_LABEL, 8'd5, 6'd63);
        send_item(CMD_LABEL, 8'd255, 6'd0);
        send_item(CMD_LABEL, 8'd6, 6'd10);
        send_item(CMD_LABEL, 8'd7, 6'd0);
        send_item(CMD_LABEL, 8'd8, 6'd0);
        send_item(CMD_LABEL, 8'd9, 6'd33);
        send_item(CMD_LABEL, 8'd0, 6'd5);
        send_item(CMD_LABEL, 8'd254, 6'd63);
        wait_idle();
    endtask

    function automatic logic [CLS_W-1:0] pick_thing();
        logic [CLS_W-1:0] c;
        for (int t = 0; t < 64; t++)
        begin
            c = CLS_W'($urandom_range(0, 255));
            if (thing_class(c)) return c;
        end
        return c;
    endfunction

    task automatic send_pixel(input logic [1:0] op, input logic [INST_W-1:0] pool_id [8],
                              input logic [CLS_W-1:0] pref [8],
                              input logic [CLS_W-1:0] stuff_set [4]);
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 7);
        if (r < 45)
            send_item(op, pref[k], pool_id[k]);
        else if (r < 60)
            send_item(op, pick_thing(), pool_id[k]);
        else if (r < 85)
            send_item(op, stuff_set[$urandom_range(0, 3)], INST_W'($urandom));
        else
            send_item(op, CLS_W'($urandom), INST_W'($urandom));
    endtask

    task automatic test_random_frame(input int f);
        logic [63:0] m [4];
        logic [DIV_W-1:0] dv;
        logic [CNT_W-1:0] lim;
        logic [INST_W-1:0] pool_id [8];
        logic [CLS_W-1:0] pref [8];
        logic [CLS_W-1:0] stuff_set [4];
        for (int k = 0; k < 4; k++)
            m[k] = {$urandom, $urandom} & {$urandom, $urandom};
        if (f == 0) m = '{64'h0, 64'h0, 64'h0, 64'h0};
        if (f == 1) m = '{'1, '1, '1, '1};
        case ($urandom_range(0, 3))
            0: dv = 17'd1;
            1: dv = 17'd65536;
            2: dv = 17'd256;
            default: dv = DIV_W'($urandom_range(1, 65536));
        endcase
        case ($urandom_range(0, 3))
            0: lim = '0;
            1: lim = 22'd2097152;
            default: lim = CNT_W'($urandom_range(1, 6));
        endcase
        set_config(m[0], m[1], m[2], m[3], dv, lim, (f % 2 == 0) ? 8'd0 : CLS_W'($urandom));
        for (int k = 0; k < 8; k++)
        begin
            pool_id[k] = INST_W'($urandom);
            pref[k] = pick_thing();
        end
        for (int k = 0; k < 4; k++)
            stuff_set[k] = CLS_W'($urandom);
        send_item(CMD_START, CLS_W'($urandom), INST_W'($urandom));
        for (int k = 0; k < 70; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_pixel(CMD_LABEL, pool_id, pref, stuff_set);
            else
                send_pixel(CMD_COLLECT, pool_id, pref, stuff_set);
            // hold the sender until the output side has caught up
            if (f == 3 && k == 35)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_labels.size() != 0) @(posedge clk);
            end
        end
        send_item(CMD_FINISH, CLS_W'($urandom), INST_W'($urandom));
        for (int k = 0; k < 50; k++)
            send_pixel(CMD_LABEL, pool_id, pref, stuff_set);
        wait_idle();
    endtask

    initial
    begin
        divisor = 17'd256;
        area_limit = '0;
        void_class = 8'd255;
        thing_mask = '{64'h0, 64'h0, 64'h0, 64'h0};
        for (int i = 0; i < N_INST; i++)
        begin
            inst_class[i] = '0;
            inst_rank[i] = '0;
            for (int c = 0; c < N_CLS; c++) vote_hist[i][c] = '0;
        end
        for (int c = 0; c < N_CLS; c++)
        begin
            stuff_area[c] = '0;
            class_tally[c] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        for (int f = 0; f < N_FRAMES; f++)
        begin
            if (f >= N_FRAMES - 3) quiet = 1'b1;
            test_random_frame(f);
        end
        repeat (20) @(posedge clk);
        if (pending_labels.size() != 0)
        begin
            $display("%0t: %0d label items never arrived", $time, pending_labels.size());
            errors++;
        end
        $display("covered %0d input items over %0d frames, %0d labels compared",
                 items_sent, N_FRAMES + 1, labels_checked);
        $display("mask, divisor, area limit and void class settings varied per frame");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
